FILE: rtl/escaped_run_length_decoder_assert.svh
// assertion macros for the escaped run-length decoder
// used by modules that include this header; expects clk and arst_n in scope
`ifndef ESCAPED_RUN_LENGTH_DECODER_ASSERT_SVH
`define ESCAPED_RUN_LENGTH_DECODER_ASSERT_SVH

// property that holds on every clock edge out of reset
`define ERLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition implies consequence in the same cycle
`define ERLD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define ERLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/erld_pkg.sv
// shared types and constants of the escaped run-length decoder
// no dependencies
`timescale 1ns / 1ps

package erld_pkg;

	localparam int unsigned MAX_UNPACKED_DEF = 49152;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned LEN_W = 16;
	localparam logic [7:0] ESC_BYTE = 8'hED;

	localparam logic RST_COMPRESSED_MODE = 1'b1;
	localparam logic [LEN_W-1:0] RST_UNPACKED_LENGTH = 16'd16384;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COMPRESSED_MODE = 1'b0,
		REG_UNPACKED_LENGTH = 1'b1
	} cfg_reg_t;

	// one encoded input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} item_t;

	// one fill command
	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [7:0]        fill_value;
		logic [7:0]        fill_length;
		logic              last_of_run;
		logic              block_full;
	} res_t;

	// what the decoder produces for one input word
	typedef struct packed {
		res_t       r0;
		res_t       r1;
		logic [1:0] count;
	} dec_out_t;

endpackage

FILE: rtl/erld_enc_if.sv
// encoded byte channel of the escaped run-length decoder
// no dependencies
`timescale 1ns / 1ps

interface erld_enc_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       final_byte;

	modport source (output valid, data_byte, first_byte, final_byte, input ready);
	modport sink (input valid, data_byte, first_byte, final_byte, output ready);
endinterface

FILE: rtl/erld_fill_if.sv
// fill command channel of the escaped run-length decoder
// depends on erld_pkg
`timescale 1ns / 1ps

interface erld_fill_if;
	logic                         valid;
	logic                         ready;
	logic [erld_pkg::ADDR_W-1:0] write_address;
	logic [7:0]                   fill_value;
	logic [7:0]                   fill_length;
	logic                         last_of_run;
	logic                         block_full;

	modport source (output valid, write_address, fill_value, fill_length, last_of_run,
		block_full, input ready);
	modport sink (input valid, write_address, fill_value, fill_length, last_of_run,
		block_full, output ready);
endinterface

FILE: rtl/erld_cfg_if.sv
// register write channel of the escaped run-length decoder
// depends on erld_pkg
`timescale 1ns / 1ps

interface erld_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [erld_pkg::CFG_INDEX_W-1:0] index;
	logic [erld_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/escaped_run_length_decoder.sv
// Escaped run-length decoder: takes one encoded byte per cycle unless the input stalls, and
// gives fill commands (address, value, length). A byte is registered on acceptance, decoded
// in the next cycle and its fill commands land in a two-entry result buffer that drives the
// port. Sustained rate is one byte per cycle while the fill channel is ready; a lone escape
// followed by an ordinary byte yields two commands, which leave the result buffer one per
// cycle, so the next byte that yields a command waits until the first of the pair has left
// and the input stalls meanwhile. Bytes that yield nothing (escape prefixes, counts, bytes
// after the block is full) never wait on the output. The user is to write registers only
// while the block is idle; the block itself does not enforce this. Write index 0 selects
// compressed mode, index 1 the unpacked length. Depends on erld_pkg, the channel interfaces,
// erld_decode and escaped_run_length_decoder_assert.svh.
`timescale 1ns / 1ps
`include "escaped_run_length_decoder_assert.svh"

module escaped_run_length_decoder #(
	parameter int unsigned MAX_UNPACKED = erld_pkg::MAX_UNPACKED_DEF
) (
	input logic            clk,
	input logic            arst_n,
	erld_enc_if.sink       enc,
	erld_fill_if.source    fill,
	erld_cfg_if.sink       cfg
);

	// configuration registers
	logic                       compressed_mode_q;
	logic [erld_pkg::LEN_W-1:0] unpacked_length_q;

	// input stage
	logic            valid_s1;
	erld_pkg::item_t item_s1;

	// result buffer, slot0 is the one on the port
	erld_pkg::res_t     slot0_q, slot1_q;
	logic [1:0]         cnt_q, cnt_n;
	erld_pkg::dec_out_t dec;

	logic pop, free, advance, push;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_mode_q <= erld_pkg::RST_COMPRESSED_MODE;
			unpacked_length_q <= erld_pkg::RST_UNPACKED_LENGTH;
		end else if (cfg.valid) begin
			unique case (erld_pkg::cfg_reg_t'(cfg.index))
				erld_pkg::REG_COMPRESSED_MODE: compressed_mode_q <= cfg.data[0];
				erld_pkg::REG_UNPACKED_LENGTH: unpacked_length_q <= cfg.data;
			endcase
		end
	end

	// handshake bookkeeping
	assign pop     = (cnt_q != 2'd0) && fill.ready;
	// buffer is empty after this edge, so a new pair may go in
	assign free    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	// a word with no commands never waits on the output
	assign advance = valid_s1 && ((dec.count == 2'd0) || free);
	assign push    = advance && (dec.count != 2'd0);
	assign enc.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (enc.valid && enc.ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (enc.valid && enc.ready) begin
			item_s1.data_byte  <= enc.data_byte;
			item_s1.first_byte <= enc.first_byte;
			item_s1.final_byte <= enc.final_byte;
		end
	end

	erld_decode #(
		.MAX_UNPACKED(MAX_UNPACKED)
	) u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item            (item_s1),
		.compressed_mode (compressed_mode_q),
		.unpacked_length (unpacked_length_q),
		.dec             (dec)
	);

	// occupancy: drop the shown entry, add what the decoder pushes
	always_comb begin
		cnt_n = cnt_q - 2'(pop);
		if (advance)
			cnt_n = cnt_n + dec.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_n;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= dec.r0;
			slot1_q <= dec.r1;
		end else if (pop && (cnt_q == 2'd2)) begin
			slot0_q <= slot1_q;
		end
	end

	assign fill.valid         = cnt_q != 2'd0;
	assign fill.write_address = slot0_q.write_address;
	assign fill.fill_value    = slot0_q.fill_value;
	assign fill.fill_length   = slot0_q.fill_length;
	assign fill.last_of_run   = slot0_q.last_of_run;
	assign fill.block_full    = slot0_q.block_full;

	`ERLD_ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "result buffer overfilled")
	`ERLD_ASSERT_SAME(a_push_free, push, free, "commands pushed into a busy buffer")
	`ERLD_ASSERT_SAME(a_pair_queued, fill.valid && !fill.last_of_run, cnt_q == 2'd2,
		"first of a pair shown without its partner")
	`ERLD_ASSERT_SAME(a_full_last, fill.valid && fill.block_full, fill.last_of_run,
		"command after the block filled")
	`ERLD_ASSERT_NEXT(a_second_follows, pop && (cnt_q == 2'd2), fill.valid && fill.last_of_run,
		"second command of a pair lost")

endmodule

FILE: rtl/erld_decode.sv
// escape state machine and fill command builder, one encoded word per advance
// depends on erld_pkg
`timescale 1ns / 1ps

module erld_decode #(
	parameter int unsigned MAX_UNPACKED = erld_pkg::MAX_UNPACKED_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  erld_pkg::item_t               item,
	input  logic                          compressed_mode,
	input  logic [erld_pkg::LEN_W-1:0]    unpacked_length,
	output erld_pkg::dec_out_t            dec
);

	typedef enum logic [1:0] {
		P_NORMAL = 2'd0,
		P_ESC1   = 2'd1,
		P_ESC2   = 2'd2,
		P_COUNT  = 2'd3
	} phase_t;

	localparam int unsigned AW = erld_pkg::ADDR_W;

	phase_t        phase_q, ph, ph_n;
	logic [7:0]    run_q, rc, rc_n;
	logic [AW-1:0] addr_q, addr, addr_n;
	logic          stop_q, stp, stp_n;

	logic [AW-1:0] lim, room, addr1, addr2;
	logic          skip, want0, want1, e0, e1, full0, full1;
	logic [7:0]    v0, len0, len0c;

	always_comb begin
		// a first word restarts the block before it is decoded
		ph   = item.first_byte ? P_NORMAL : phase_q;
		rc   = item.first_byte ? 8'd0 : run_q;
		addr = item.first_byte ? '0 : addr_q;
		stp  = item.first_byte ? 1'b0 : stop_q;

		lim  = ({1'b0, unpacked_length} > 17'(MAX_UNPACKED)) ? AW'(MAX_UNPACKED)
			: unpacked_length;
		skip = stp || (addr >= lim);

		ph_n  = ph;
		rc_n  = rc;
		stp_n = stp;
		want0 = 1'b0;
		want1 = 1'b0;
		v0    = item.data_byte;
		len0  = 8'd1;

		if (!skip) begin
			if (!compressed_mode) begin
				ph_n  = P_NORMAL;
				want0 = 1'b1;
			end else begin
				unique case (ph)
					P_NORMAL: begin
						if (item.data_byte == erld_pkg::ESC_BYTE && !item.final_byte)
							ph_n = P_ESC1;
						else
							want0 = 1'b1;
					end
					P_ESC1: begin
						if (item.data_byte == erld_pkg::ESC_BYTE) begin
							if (item.final_byte)
								stp_n = 1'b1;
							else
								ph_n = P_ESC2;
						end else begin
							// lone escape: literal escape, then this byte
							ph_n  = P_NORMAL;
							want0 = 1'b1;
							want1 = 1'b1;
							v0    = erld_pkg::ESC_BYTE;
						end
					end
					P_ESC2: begin
						if (item.final_byte) begin
							stp_n = 1'b1;
							ph_n  = P_NORMAL;
						end else begin
							rc_n = item.data_byte;
							ph_n = P_COUNT;
						end
					end
					P_COUNT: begin
						ph_n  = P_NORMAL;
						want0 = 1'b1;
						len0  = rc;
						rc_n  = 8'd0;
					end
				endcase
			end
			if (item.final_byte)
				stp_n = 1'b1;
		end

		// clip to the room left in the block
		e0    = want0 && (len0 != 8'd0);
		room  = lim - addr;
		len0c = ({8'd0, len0} > room) ? room[7:0] : len0;
		addr1 = addr + AW'(len0c);
		full0 = addr1 >= lim;
		e1    = want1 && !full0;
		addr2 = addr1 + AW'(1);
		full1 = addr2 >= lim;

		addr_n = e1 ? addr2 : (e0 ? addr1 : addr);

		dec.r0.write_address = addr;
		dec.r0.fill_value    = v0;
		dec.r0.fill_length   = len0c;
		dec.r0.last_of_run   = !e1;
		dec.r0.block_full    = full0;
		dec.r1.write_address = addr1;
		dec.r1.fill_value    = item.data_byte;
		dec.r1.fill_length   = 8'd1;
		dec.r1.last_of_run   = 1'b1;
		dec.r1.block_full    = full1;
		dec.count            = 2'(e0) + 2'(e1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_NORMAL;
			run_q   <= 8'd0;
			addr_q  <= '0;
			stop_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= ph_n;
			run_q   <= rc_n;
			addr_q  <= addr_n;
			stop_q  <= stp_n;
		end
	end

endmodule

FILE: tb/escaped_run_length_decoder_test.sv
// self-checking bench for escaped_run_length_decoder: directed escape cases, then random blocks
// depends on erld_pkg, erld_enc_if, erld_fill_if, erld_cfg_if and the decoder rtl
`timescale 1ns / 1ps

module escaped_run_length_decoder_test;

	// decoder position inside an escape sequence
	typedef enum bit [1:0] {
		PH_NORMAL = 2'd0,	// plain literal bytes
		PH_ESC    = 2'd1,	// one ED seen
		PH_ESC2   = 2'd2,	// ED ED seen, count comes next
		PH_COUNT  = 2'd3	// count held, value comes next
	} esc_phase_t;

	// tracks the decoder state, predicts fill commands per word and checks them in order
	class fill_tracker;
		bit                  comp_mode;
		logic [15:0]         unp_len;
		esc_phase_t          phase;
		logic [7:0]          run_cnt;
		int unsigned         next_addr;
		bit                  stopped;
		erld_pkg::res_t      word_fills[$];
		erld_pkg::res_t      expected_fills[$];
		int unsigned         mismatches;

		function new();
			comp_mode = erld_pkg::RST_COMPRESSED_MODE;
			unp_len = erld_pkg::RST_UNPACKED_LENGTH;
			phase = PH_NORMAL;
			run_cnt = '0;
			next_addr = 0;
			stopped = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(erld_pkg::cfg_reg_t idx, logic [erld_pkg::CFG_DATA_W-1:0] value);
			case (idx)
			erld_pkg::REG_COMPRESSED_MODE: comp_mode = value[0];
			erld_pkg::REG_UNPACKED_LENGTH: unp_len = value;
			default: ;
			endcase
		endfunction

		// out-of-range lengths clamp to the largest block
		function int unsigned fill_limit();
			return (unp_len > erld_pkg::MAX_UNPACKED_DEF) ? erld_pkg::MAX_UNPACKED_DEF
				: int'(unp_len);
		endfunction

		// one fill, clipped at the limit; nothing once the block is full
		function void push_fill(logic [7:0] value, int unsigned len);
			int unsigned lim;
			erld_pkg::res_t r;
			lim = fill_limit();
			if (len == 0 || next_addr >= lim)
				return;
			if (len > lim - next_addr)
				len = lim - next_addr;
			r.write_address = next_addr[erld_pkg::ADDR_W-1:0];
			r.fill_value = value;
			r.fill_length = len[7:0];
			r.last_of_run = 1'b0;
			next_addr += len;
			r.block_full = (next_addr >= lim);
			word_fills.push_back(r);
		endfunction

		// accepted input word; returns 0 if the decoder ignores it
		function bit decode_word(erld_pkg::item_t w);
			word_fills.delete();
			if (w.first_byte) begin
				phase = PH_NORMAL;
				run_cnt = '0;
				next_addr = 0;
				stopped = 1'b0;
			end
			if (stopped || next_addr >= fill_limit())
				return 1'b0;
			if (!comp_mode) begin
				phase = PH_NORMAL;
				push_fill(w.data_byte, 1);
			end else begin
				case (phase)
				PH_NORMAL: begin
					if (w.data_byte == erld_pkg::ESC_BYTE && !w.final_byte)
						phase = PH_ESC;
					else
						push_fill(w.data_byte, 1);
				end
				PH_ESC: begin
					if (w.data_byte == erld_pkg::ESC_BYTE) begin
						if (w.final_byte)
							stopped = 1'b1;
						else
							phase = PH_ESC2;
					end else begin
						phase = PH_NORMAL;
						push_fill(erld_pkg::ESC_BYTE, 1);
						push_fill(w.data_byte, 1);
					end
				end
				PH_ESC2: begin
					if (w.final_byte) begin
						stopped = 1'b1;
						phase = PH_NORMAL;
					end else begin
						run_cnt = w.data_byte;
						phase = PH_COUNT;
					end
				end
				default: begin
					phase = PH_NORMAL;
					push_fill(w.data_byte, run_cnt);
					run_cnt = '0;
				end
				endcase
			end
			if (w.final_byte)
				stopped = 1'b1;
			if (word_fills.size() > 0)
				word_fills[word_fills.size() - 1].last_of_run = 1'b1;
			foreach (word_fills[i])
				expected_fills.push_back(word_fills[i]);
			return 1'b1;
		endfunction

		function void flag_field(string what, int unsigned want, int unsigned got);
			$display("%0t: fill %s expected %0d actual %0d", $time, what, want, got);
			mismatches++;
		endfunction

		function void check_fill(erld_pkg::res_t got);
			erld_pkg::res_t want;
			if (expected_fills.size() == 0) begin
				$display("%0t: fill expected none actual addr %0d value %0d len %0d",
					$time, got.write_address, got.fill_value, got.fill_length);
				mismatches++;
				return;
			end
			want = expected_fills.pop_front();
			if (got.write_address !== want.write_address)
				flag_field("write_address", want.write_address, got.write_address);
			if (got.fill_value !== want.fill_value)
				flag_field("fill_value", want.fill_value, got.fill_value);
			if (got.fill_length !== want.fill_length)
				flag_field("fill_length", want.fill_length, got.fill_length);
			if (got.last_of_run !== want.last_of_run)
				flag_field("last_of_run", want.last_of_run, got.last_of_run);
			if (got.block_full !== want.block_full)
				flag_field("block_full", want.block_full, got.block_full);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	erld_enc_if  enc_ch();
	erld_fill_if fill_ch();
	erld_cfg_if  cfg_ch();

	escaped_run_length_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_ch),
		.fill   (fill_ch),
		.cfg    (cfg_ch)
	);

	fill_tracker     board;
	erld_pkg::item_t word_queue[$];	// words waiting to be sent
	int unsigned     gap_pct;		// chance in 100 that the sender idles a cycle
	int unsigned     stall_pct;		// chance in 100 that the receiver stalls a cycle

	// 2 ns period
	always #1 clk = ~clk;

	// fill command receiver: random back-pressure, check on every accepted word
	always @(posedge clk) begin
		if (arst_n && fill_ch.valid && fill_ch.ready) begin
			board.check_fill('{fill_ch.write_address, fill_ch.fill_value, fill_ch.fill_length,
				fill_ch.last_of_run, fill_ch.block_full});
		end
		fill_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic erld_pkg::item_t mk(logic [7:0] b, logic first, logic last);
		erld_pkg::item_t w;
		w.data_byte = b;
		w.first_byte = first;
		w.final_byte = last;
		return w;
	endfunction

	// one word through the encoded channel; valid stays high into the next call
	// unless that call decides to idle, so valid never gets two updates in one step
	task automatic send_word(input erld_pkg::item_t w);
		while ($urandom_range(99) < gap_pct) begin
			enc_ch.valid <= 1'b0;
			@(posedge clk);
		end
		enc_ch.valid <= 1'b1;
		enc_ch.data_byte <= w.data_byte;
		enc_ch.first_byte <= w.first_byte;
		enc_ch.final_byte <= w.final_byte;
		@(posedge clk);
		while (!enc_ch.ready)
			@(posedge clk);
		void'(board.decode_word(w));
	endtask

	task automatic send_queue();
		while (word_queue.size() > 0)
			send_word(word_queue.pop_front());
	endtask

	// stop sending, let every expected fill arrive, then cover the pipeline
	// depth for words that produce nothing (escape prefixes, counts, ignored bytes)
	task automatic idle_pause();
		enc_ch.valid <= 1'b0;
		while (board.expected_fills.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers back to back, valid held high between the two writes
	task automatic set_config(bit mode, logic [15:0] len);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= erld_pkg::REG_COMPRESSED_MODE;
		cfg_ch.data <= {{(erld_pkg::CFG_DATA_W-1){1'b0}}, mode};
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.set_reg(erld_pkg::REG_COMPRESSED_MODE, {{(erld_pkg::CFG_DATA_W-1){1'b0}}, mode});
		cfg_ch.index <= erld_pkg::REG_UNPACKED_LENGTH;
		cfg_ch.data <= len;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.set_reg(erld_pkg::REG_UNPACKED_LENGTH, len);
		cfg_ch.valid <= 1'b0;
	endtask

	// random block: mostly well-formed literals and runs, some noise,
	// and an ending that is either clean, a trailing ED, a cut-short escape or none at all
	function automatic void add_block();
		int unsigned start;
		int unsigned toks;
		logic [7:0] b;
		logic [7:0] cnt;
		start = word_queue.size();
		toks = $urandom_range(30, 2);
		repeat (toks) begin
			cnt = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8, 1));
			case ($urandom_range(9))
			0, 1, 2, 3, 4: word_queue.push_back(mk(8'($urandom_range(255)), 1'b0, 1'b0));
			5, 6, 8: begin
				// run; a zero count writes nothing
				word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
				word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
				word_queue.push_back(mk((cnt == 0 || $urandom_range(9) == 0) ? 8'h00 : cnt,
					1'b0, 1'b0));
				word_queue.push_back(mk(8'($urandom_range(255)), 1'b0, 1'b0));
			end
			7: begin
				// lone escape, then a plain byte
				b = 8'($urandom_range(255));
				if (b == erld_pkg::ESC_BYTE)
					b = 8'h00;
				word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
				word_queue.push_back(mk(b, 1'b0, 1'b0));
			end
			default: begin
				word_queue.push_back(mk(8'($urandom_range(255)), $urandom_range(19) == 0,
					$urandom_range(19) == 0));
			end
			endcase
		end
		case ($urandom_range(4))
		0: word_queue[word_queue.size() - 1].final_byte = 1'b1;
		1: word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b1));
		2: begin
			word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
			word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b1));
		end
		3: begin
			word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
			word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
			word_queue.push_back(mk(8'($urandom_range(255)), 1'b0, 1'b1));
		end
		default: ;
		endcase
		word_queue[start].first_byte = 1'b1;
	endfunction

	// register settings of the random phases, extremes included
	bit          phase_mode[9] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	int unsigned phase_len[9]  = '{64, 1, 300, 49152, 65535, 0, 49152, 500, 1};

	initial begin
		int unsigned sent_cnt;
		int unsigned quota;

		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		enc_ch.valid = 1'b0;
		enc_ch.data_byte = '0;
		enc_ch.first_byte = 1'b0;
		enc_ch.final_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = erld_pkg::REG_COMPRESSED_MODE;
		cfg_ch.data = '0;
		fill_ch.ready = 1'b0;
		gap_pct = 17;
		stall_pct = 80;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, block of 20 bytes so the limit is reached
		set_config(1'b1, 16'd20);
		word_queue.push_back(mk(8'h00, 1'b1, 1'b0));		// smallest literal
		word_queue.push_back(mk(8'hFF, 1'b0, 1'b0));		// largest literal
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));	// run of 5
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h05, 1'b0, 1'b0));
		word_queue.push_back(mk(8'hAA, 1'b0, 1'b0));
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));	// lone escape: two fills
		word_queue.push_back(mk(8'h12, 1'b0, 1'b0));
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));	// zero count
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h00, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h33, 1'b0, 1'b0));
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));	// run of 255, clipped
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
		word_queue.push_back(mk(8'hFF, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h44, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h55, 1'b0, 1'b0));		// block full: ignored
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b1, 1'b0));	// cut short on second escape
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b1));
		word_queue.push_back(mk(8'h77, 1'b0, 1'b0));		// after final: ignored
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b1, 1'b1));	// escape as final: literal
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b1, 1'b0));	// cut short on the count
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h03, 1'b0, 1'b1));
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b1, 1'b0));	// escape left open
		send_queue();

		// copy mode while an escape is pending: phase drops, escape copied as is
		idle_pause();
		set_config(1'b0, 16'd20);
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h12, 1'b0, 1'b0));
		send_queue();
		idle_pause();
		set_config(1'b1, 16'd20);
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));	// run ending on final byte
		word_queue.push_back(mk(erld_pkg::ESC_BYTE, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h03, 1'b0, 1'b0));
		word_queue.push_back(mk(8'h99, 1'b0, 1'b1));
		send_queue();

		// random phases; idle pattern moves from slow receiver to slow sender to none
		for (int p = 0; p < 9; p++) begin
			idle_pause();
			set_config(phase_mode[p], phase_len[p][15:0]);
			if (p == 3) begin
				gap_pct = 80;
				stall_pct = 17;
			end else if (p == 6) begin
				gap_pct = 0;
				stall_pct = 0;
			end
			word_queue.delete();
			quota = 1200 / 9;
			sent_cnt = 0;
			// ignored words count as sent words too
			while (sent_cnt < quota) begin
				if (word_queue.size() == 0)
					add_block();
				send_word(word_queue.pop_front());
				sent_cnt++;
			end
		end

		idle_pause();
		repeat (4) @(posedge clk);
		if (board.mismatches == 0 && board.expected_fills.size() == 0) begin
			$display("[escaped_run_length_decoder] OK");
		end else begin
			if (board.expected_fills.size() != 0)
				$display("%0t: %0d fill commands never arrived", $time,
					board.expected_fills.size());
			$display("[escaped_run_length_decoder] ERROR");
		end
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#1000000;
		$display("[escaped_run_length_decoder] ERROR");
		$finish;
	end

endmodule
